/* rtl/fccm_pkg.sv */
package fccm_pkg;

  // Default geometry of the allocation map
  localparam int unsigned NUM_CLUSTERS_DEF  = 512;
  localparam int unsigned CLUSTER_BYTES_DEF = 2048;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int START_W  = 9;
  localparam int BYTES_W  = 21;
  localparam int STATUS_W = 2;
  localparam int FIRST_W  = 9;
  localparam int ENTRY_W  = 32;
  localparam int TOTAL_W  = 10;
  localparam int LINK_W   = 28;

  // Stream packing
  localparam int IN_TDATA_W    = 32;
  localparam int IN_START_LSB  = 0;
  localparam int IN_BYTES_LSB  = IN_START_LSB + START_W;
  localparam int IN_USED_W     = START_W + BYTES_W;
  localparam int OUT_STATUS_LSB = 0;
  localparam int OUT_FIRST_LSB  = OUT_STATUS_LSB + STATUS_W;
  localparam int OUT_ENTRY_LSB  = OUT_FIRST_LSB + FIRST_W;
  localparam int OUT_TOTAL_LSB  = OUT_ENTRY_LSB + ENTRY_W;
  localparam int OUT_USED_W     = OUT_TOTAL_LSB + TOTAL_W;
  localparam int OUT_TDATA_W    = 56;
  localparam int OUT_PAD_W      = OUT_TDATA_W - OUT_USED_W;

  // Commands
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_START = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BROKEN    = 2'd3;

  // Map entry encoding
  localparam int unsigned FIRST_FREE   = 3;
  localparam int unsigned ROOT_CLUSTER = 2;
  localparam logic [ENTRY_W-1:0] RSVD0_VALUE = 32'h0FFF_FFF0;
  localparam logic [ENTRY_W-1:0] RSVD1_VALUE = 32'h0FFF_FFFF;
  localparam logic [ENTRY_W-1:0] END_MARK    = 32'h0FFF_FFFF;
  localparam logic [LINK_W-1:0]  END_MIN     = 28'hFFF_FFF8;

  // Microcode
  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_WAIT,
    OP_IS_ALLOC,
    OP_IS_FREE,
    OP_IS_READ,
    OP_RD_TAKE,
    OP_A_COUNT,
    OP_A_SEL,
    OP_A_TAKE,
    OP_A_END,
    OP_F_TEST,
    OP_F_ZERO,
    OP_EMIT
  } op_e;

  // J_HIT/J_MISS: jump to target on hit/miss, else next step
  // J_WAIT: jump to target on hit, else stay
  typedef enum logic [1:0] {
    J_GOTO,
    J_HIT,
    J_MISS,
    J_WAIT
  } jump_e;

  typedef logic [3:0] step_t;

  localparam step_t S_CLEAR    = 4'd0;
  localparam step_t S_WAIT     = 4'd1;
  localparam step_t S_IS_ALLOC = 4'd2;
  localparam step_t S_IS_FREE  = 4'd3;
  localparam step_t S_IS_READ  = 4'd4;
  localparam step_t S_RD_TAKE  = 4'd5;
  localparam step_t S_A_COUNT  = 4'd6;
  localparam step_t S_A_SEL    = 4'd7;
  localparam step_t S_A_TAKE   = 4'd8;
  localparam step_t S_A_END    = 4'd9;
  localparam step_t S_F_TEST   = 4'd10;
  localparam step_t S_F_ZERO   = 4'd11;
  localparam step_t S_EMIT     = 4'd12;

  typedef struct packed {
    op_e   op;
    jump_e jump;
    step_t target;
  } uword_t;

  function automatic uword_t ucode(step_t s);
    uword_t w;
    case (s)
      S_CLEAR:    w = '{op: OP_CLEAR,    jump: J_MISS, target: S_CLEAR};
      S_WAIT:     w = '{op: OP_WAIT,     jump: J_WAIT, target: S_IS_ALLOC};
      S_IS_ALLOC: w = '{op: OP_IS_ALLOC, jump: J_HIT,  target: S_A_COUNT};
      S_IS_FREE:  w = '{op: OP_IS_FREE,  jump: J_HIT,  target: S_F_TEST};
      S_IS_READ:  w = '{op: OP_IS_READ,  jump: J_MISS, target: S_EMIT};
      S_RD_TAKE:  w = '{op: OP_RD_TAKE,  jump: J_GOTO, target: S_EMIT};
      S_A_COUNT:  w = '{op: OP_A_COUNT,  jump: J_MISS, target: S_A_COUNT};
      S_A_SEL:    w = '{op: OP_A_SEL,    jump: J_HIT,  target: S_EMIT};
      S_A_TAKE:   w = '{op: OP_A_TAKE,   jump: J_MISS, target: S_A_TAKE};
      S_A_END:    w = '{op: OP_A_END,    jump: J_GOTO, target: S_EMIT};
      S_F_TEST:   w = '{op: OP_F_TEST,   jump: J_HIT,  target: S_EMIT};
      S_F_ZERO:   w = '{op: OP_F_ZERO,   jump: J_MISS, target: S_F_TEST};
      S_EMIT:     w = '{op: OP_EMIT,     jump: J_WAIT, target: S_WAIT};
      default:    w = '{op: OP_NOP,      jump: J_GOTO, target: S_WAIT};
    endcase
    return w;
  endfunction

endpackage

/* rtl/fccm_ram.sv */
module fccm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/fat_cluster_chain_manager_unit.sv */
// Commands: a read looks up one entry; a free zeroes each cluster of the chain in turn,
//   following the links, and stops early when the walk meets a free entry; an allocate runs
//   a count pass over the map, then a link pass (only the count pass if there is no room).
// Commands are taken one at a time; the single map read port is visited once per entry by
//   the scan or walk loops.
// Reset: async, active low; then a clearing pass over every map entry, s_axis_tready_o low.
module fat_cluster_chain_manager_unit
  import fccm_pkg::*;
#(
  parameter int unsigned NUM_CLUSTERS  = NUM_CLUSTERS_DEF,
  parameter int unsigned CLUSTER_BYTES = CLUSTER_BYTES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Command beat
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // start_cluster[8:0], byte_size[29:9]
  input  logic [CMD_W-1:0]       s_axis_tuser_i,   // command[1:0]
  // Result beat
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o    // status[1:0], first_cluster[10:2],
                                                   // entry_value[42:11], cluster_total[52:43]
);

  localparam int IW   = $clog2(NUM_CLUSTERS);
  localparam int CW   = $clog2(NUM_CLUSTERS + 1);
  localparam int AccW = $clog2(longint'(NUM_CLUSTERS) * longint'(CLUSTER_BYTES) + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_CLUSTERS - 1);

  // Sequencer and datapath registers
  step_t                upc_q, upc_d;
  logic [IW-1:0]        a_q, a_d;          // current cluster; read address is a_d
  logic [IW-1:0]        head_q, head_d;
  logic [IW-1:0]        prev_q, prev_d;
  logic [CW-1:0]        cnt_q, cnt_d;      // clusters taken or freed
  logic [AccW-1:0]      acc_q, acc_d;      // bytes covered by counted clusters
  logic [CMD_W-1:0]     cmd_q, cmd_d;
  logic [START_W-1:0]   start_q, start_d;
  logic [BYTES_W-1:0]   bytes_q, bytes_d;
  logic [STATUS_W-1:0]  status_q, status_d;
  logic [ENTRY_W-1:0]   entry_q, entry_d;
  // Output register
  logic                 ovalid_q, ovalid_d;
  logic [OUT_TDATA_W-1:0] odata_q, odata_d;

  // Map port
  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [ENTRY_W-1:0]   rdata;

  uword_t               uw;
  logic                 hit;

  // Decoded helpers
  logic [AccW-1:0]      acc_sum;
  logic                 covered;           // counted clusters cover the byte size
  logic                 is_free;
  logic                 is_last;
  logic                 start_lo, start_big, start_bad;
  logic [LINK_W-1:0]    link;
  logic                 link_end, link_bad;
  logic [FIRST_W-1:0]   first_val;

  assign uw = ucode(upc_q);

  assign acc_sum   = acc_q + AccW'(CLUSTER_BYTES);
  assign covered   = 32'(acc_sum) >= 32'(bytes_q);
  assign is_free   = (rdata == '0);
  assign is_last   = (a_q == LAST_IDX);
  assign start_lo  = start_q < START_W'(FIRST_FREE);
  assign start_big = 32'(start_q) >= 32'(NUM_CLUSTERS);
  assign start_bad = start_lo || start_big;
  assign link      = rdata[LINK_W-1:0];
  assign link_end  = link >= END_MIN;
  // A link back to the entry being zeroed is a loop: its target is free by then.
  assign link_bad  = (link < LINK_W'(FIRST_FREE)) || (link >= LINK_W'(NUM_CLUSTERS)) ||
                     (link == LINK_W'(a_q));
  assign first_val = ((cmd_q == CMD_ALLOC) && (status_q == ST_OK)) ? FIRST_W'(head_q) : '0;

  always_comb begin
    a_d       = a_q;
    head_d    = head_q;
    prev_d    = prev_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    cmd_d     = cmd_q;
    start_d   = start_q;
    bytes_d   = bytes_q;
    status_d  = status_q;
    entry_d   = entry_q;
    ovalid_d  = ovalid_q && !m_axis_tready_i;
    odata_d   = odata_q;
    ram_we    = 1'b0;
    ram_waddr = a_q;
    ram_wdata = '0;
    hit       = 1'b0;

    case (uw.op)
      OP_CLEAR: begin
        // Post-reset sweep, one entry per cycle
        ram_we = 1'b1;
        if (a_q == IW'(0)) begin
          ram_wdata = RSVD0_VALUE;
        end else if (a_q == IW'(1)) begin
          ram_wdata = RSVD1_VALUE;
        end else if (a_q == IW'(ROOT_CLUSTER)) begin
          ram_wdata = END_MARK;
        end
        a_d = a_q + IW'(1);
        hit = is_last;
      end
      OP_WAIT: begin
        hit = s_axis_tvalid_i;
        if (hit) begin
          cmd_d    = s_axis_tuser_i;
          start_d  = s_axis_tdata_i[IN_START_LSB +: START_W];
          bytes_d  = s_axis_tdata_i[IN_BYTES_LSB +: BYTES_W];
          status_d = ST_OK;
          entry_d  = '0;
          cnt_d    = '0;
          acc_d    = '0;
        end
      end
      OP_IS_ALLOC: begin
        hit = (cmd_q == CMD_ALLOC);
        a_d = IW'(FIRST_FREE);
      end
      OP_IS_FREE: begin
        hit = (cmd_q == CMD_FREE);
        a_d = IW'(start_q);
      end
      OP_IS_READ: begin
        hit = (cmd_q == CMD_READ);
      end
      OP_RD_TAKE: begin
        if (start_big) begin
          status_d = ST_BAD_START;
        end else begin
          entry_d = rdata;
        end
      end
      OP_A_COUNT: begin
        // First pass: count free entries until they cover the request
        if (is_free && covered) begin
          hit   = 1'b1;
          a_d   = IW'(FIRST_FREE);
          acc_d = '0;
        end else begin
          hit = is_last;
          a_d = a_q + IW'(1);
          if (is_free) begin
            acc_d = acc_sum;
          end
          if (is_last) begin
            status_d = ST_NO_SPACE;
          end
        end
      end
      OP_A_SEL: begin
        hit = (status_q == ST_NO_SPACE);
      end
      OP_A_TAKE: begin
        // Second pass: link each free entry from the previous one
        a_d = a_q + IW'(1);
        hit = is_last || (is_free && covered);
        if (is_free) begin
          cnt_d  = cnt_q + CW'(1);
          acc_d  = acc_sum;
          prev_d = a_q;
          if (cnt_q == '0) begin
            head_d = a_q;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = prev_q;
            ram_wdata = ENTRY_W'(a_q);
          end
        end
      end
      OP_A_END: begin
        ram_we    = 1'b1;
        ram_waddr = prev_q;
        ram_wdata = END_MARK;
      end
      OP_F_TEST: begin
        // Target must be in use; the head must also be in range
        hit = is_free || ((cnt_q == '0) && start_bad);
        if (hit) begin
          status_d = (cnt_q == '0) ? ST_BAD_START : ST_BROKEN;
        end
      end
      OP_F_ZERO: begin
        ram_we    = 1'b1;
        ram_waddr = a_q;
        ram_wdata = '0;
        cnt_d     = cnt_q + CW'(1);
        hit       = link_end || link_bad;
        if (!link_end && link_bad) begin
          status_d = ST_BROKEN;
        end
        if (!hit) begin
          a_d = IW'(link);
        end
      end
      OP_EMIT: begin
        hit = !ovalid_q || m_axis_tready_i;
        if (hit) begin
          ovalid_d = 1'b1;
          odata_d  = {{OUT_PAD_W{1'b0}}, TOTAL_W'(cnt_q), entry_q, first_val, status_q};
        end
      end
      default: begin
      end
    endcase

    case (uw.jump)
      J_GOTO:  upc_d = uw.target;
      J_HIT:   upc_d = hit ? uw.target : upc_q + step_t'(1);
      J_MISS:  upc_d = hit ? upc_q + step_t'(1) : uw.target;
      J_WAIT:  upc_d = hit ? uw.target : upc_q;
      default: upc_d = S_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q    <= S_CLEAR;
      a_q      <= '0;
      head_q   <= '0;
      prev_q   <= '0;
      cnt_q    <= '0;
      acc_q    <= '0;
      cmd_q    <= '0;
      start_q  <= '0;
      bytes_q  <= '0;
      status_q <= ST_OK;
      entry_q  <= '0;
      ovalid_q <= 1'b0;
      odata_q  <= '0;
    end else begin
      upc_q    <= upc_d;
      a_q      <= a_d;
      head_q   <= head_d;
      prev_q   <= prev_d;
      cnt_q    <= cnt_d;
      acc_q    <= acc_d;
      cmd_q    <= cmd_d;
      start_q  <= start_d;
      bytes_q  <= bytes_d;
      status_q <= status_d;
      entry_q  <= entry_d;
      ovalid_q <= ovalid_d;
      odata_q  <= odata_d;
    end
  end

  // Allocation map; read address is the next cluster so data lines up with a_q
  fccm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NUM_CLUSTERS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (a_d),
    .rdata_o (rdata)
  );

  assign s_axis_tready_o = (uw.op == OP_WAIT);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;

endmodule

/* rtl/fccm_checker.sv */
module fccm_checker
  import fccm_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_tvalid_i,
  input logic                   s_tready_i,
  input logic                   m_tvalid_i,
  input logic                   m_tready_i,
  input logic [OUT_TDATA_W-1:0] m_tdata_i
);

  logic [STATUS_W-1:0] status;
  logic [FIRST_W-1:0]  first;
  logic [ENTRY_W-1:0]  entry;
  logic [TOTAL_W-1:0]  total;

  assign status = m_tdata_i[OUT_STATUS_LSB +: STATUS_W];
  assign first  = m_tdata_i[OUT_FIRST_LSB +: FIRST_W];
  assign entry  = m_tdata_i[OUT_ENTRY_LSB +: ENTRY_W];
  assign total  = m_tdata_i[OUT_TOTAL_LSB +: TOTAL_W];

  // One command in flight: no back-to-back command beats
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i |=> !s_tready_i)
    else $error("command accepted in the cycle after another");

  // Only a successful command reports a head cluster
  a_first_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (first != '0) |-> status == ST_OK)
    else $error("head cluster on a failed command");

  // A read that fails returns no entry
  a_entry_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (entry != '0) |-> status == ST_OK)
    else $error("entry value on a failed command");

  // A failed allocation touches nothing
  a_nospace: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (status == ST_NO_SPACE) |-> (total == '0) && (first == '0))
    else $error("no-space result reports clusters");

  // Stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i))
    else $error("result beat changed while stalled");

endmodule

bind fat_cluster_chain_manager_unit fccm_checker u_fccm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o)
);
